// ----- sv/rbsi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared constants and types for the ray versus cube slab intersection block.
// ----------------------------------------------------------------------------
package rbsi_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int CFG_IDX_W       = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_EDGE  = 3'd3
    } t_cfg_reg;

    typedef logic signed [1:0] t_norm;
    localparam t_norm NORM_ZERO = 2'sb00;
    localparam t_norm NORM_POS  = 2'sb01;
    localparam t_norm NORM_NEG  = 2'sb11;

endpackage

// ----- sv/rbsi_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_div
// Pipelined restoring divider: num * 2^F / den, one quotient bit per stage,
// magnitude truncated toward zero, saturated to the signed W-bit range.
// ----------------------------------------------------------------------------
module rbsi_div #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W+1:0] i_num,
    input  logic signed [W-1:0] i_den,
    output logic signed [W-1:0] o_quo
);
    localparam int RW = 2 * W + F;

    logic [RW-1:0] r_rem [W];
    logic [W-1:0]  r_den [W];
    logic [W-2:0]  r_q   [W];
    logic          r_neg [W];
    logic          r_ovf [W];

    logic [W+1:0]  n_nmag;
    logic [W-1:0]  n_dmag;
    logic [RW-1:0] n_nsh;
    logic [RW-1:0] n_dsh;

    always_comb begin
        n_nmag = i_num[W+1] ? (W+2)'(-i_num) : i_num;
        n_dmag = i_den[W-1] ? W'(-i_den) : i_den;
        n_nsh  = RW'(n_nmag) << F;
        n_dsh  = RW'(n_dmag) << (W - 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_nsh;
            r_den[0] <= n_dmag;
            r_q[0]   <= '0;
            r_neg[0] <= i_num[W+1] ^ i_den[W-1];
            r_ovf[0] <= (n_nsh >= n_dsh);
        end
    end

    for (genvar k = 1; k < W; k++) begin : g_stage
        localparam int B = W - 1 - k;
        logic [RW-1:0] n_sub;
        logic          n_ge;
        always_comb begin
            n_sub = RW'(r_den[k-1]) << B;
            n_ge  = (r_rem[k-1] >= n_sub);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]    <= n_ge ? (r_rem[k-1] - n_sub) : r_rem[k-1];
                r_den[k]    <= r_den[k-1];
                r_q[k]      <= r_q[k-1] | ((W-1)'(n_ge) << B);
                r_neg[k]    <= r_neg[k-1];
                r_ovf[k]    <= r_ovf[k-1];
            end
        end
    end

    logic signed [W-1:0] n_mag;
    always_comb begin
        n_mag = {1'b0, r_q[W-1]};
        if (r_ovf[W-1]) begin
            o_quo = r_neg[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            o_quo = r_neg[W-1] ? -n_mag : n_mag;
        end
    end

endmodule

// ----- sv/ray_box_slab_intersect_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_top
// Ray versus axis-aligned cube test by the slab method in signed fixed point,
// giving hit, entry/exit parameter, hit point and face normal.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  ray     | in        | i_valid / o_stall  | origin, dir, t_lower, t_upper
//  result  | out       | o_valid / i_stall  | hit, t_hit, point, normal
//  config  | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
//  One ray per cycle while the pipeline is not stalled; the depth is set by the
//  one-bit-per-stage slab dividers (six in parallel).
//  Reset clears valid bits and loads the cube registers (corner 0, edge 1.0).
//  A result held by i_stall freezes the whole pipeline; o_stall follows it.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_top #(
    parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rbsi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]          i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [COORD_WIDTH-1:0]   i_origin_x,
    input  logic signed [COORD_WIDTH-1:0]   i_origin_y,
    input  logic signed [COORD_WIDTH-1:0]   i_origin_z,
    input  logic signed [COORD_WIDTH-1:0]   i_dir_x,
    input  logic signed [COORD_WIDTH-1:0]   i_dir_y,
    input  logic signed [COORD_WIDTH-1:0]   i_dir_z,
    input  logic signed [COORD_WIDTH-1:0]   i_t_lower,
    input  logic signed [COORD_WIDTH-1:0]   i_t_upper,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_hit,
    output logic signed [COORD_WIDTH-1:0]   o_t_hit,
    output logic signed [COORD_WIDTH-1:0]   o_point_x,
    output logic signed [COORD_WIDTH-1:0]   o_point_y,
    output logic signed [COORD_WIDTH-1:0]   o_point_z,
    output logic signed [1:0]               o_normal_x,
    output logic signed [1:0]               o_normal_y,
    output logic signed [1:0]               o_normal_z
);
    import rbsi_pkg::*;

    localparam int W = COORD_WIDTH;
    localparam int F = FRAC_BITS;
    localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W+1:0] CMAX2 = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0] CMIN2 = {3'b111, {(W-1){1'b0}}};

    typedef struct packed {
        logic [2:0][W-1:0] org;
        logic [2:0][W-1:0] dir;
        logic [W-1:0]      lower;
        logic [W-1:0]      upper;
    } t_ray;

    typedef struct packed {
        t_ray       ray;
        logic [2:0] bnd;
        logic       zmiss;
    } t_side;

    // ---------------- configuration ----------------
    logic [W-1:0] r_bmin [3];
    logic [W-2:0] r_edge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bmin[0] <= '0;
            r_bmin[1] <= '0;
            r_bmin[2] <= '0;
            r_edge    <= (W-1)'(1) << F;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MIN_X: r_bmin[0] <= i_cfg_data;
                REG_MIN_Y: r_bmin[1] <= i_cfg_data;
                REG_MIN_Z: r_bmin[2] <= i_cfg_data;
                REG_EDGE:  r_edge    <= i_cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // ---------------- input register ----------------
    t_ray r_in;
    logic r_in_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (en) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in.org   <= {i_origin_z, i_origin_y, i_origin_x};
            r_in.dir   <= {i_dir_z, i_dir_y, i_dir_x};
            r_in.lower <= i_t_lower;
            r_in.upper <= i_t_upper;
        end
    end

    // ---------------- slab numerators ----------------
    logic signed [W+1:0] n_num0 [3];
    logic signed [W+1:0] n_num1 [3];
    logic [2:0]          n_zout;
    logic [2:0]          n_bnd;

    always_comb begin
        logic signed [W+1:0] lo, hi, o;
        for (int a = 0; a < 3; a++) begin
            lo = {{2{r_bmin[a][W-1]}}, r_bmin[a]};
            hi = lo + {3'b000, r_edge};
            o  = {{2{r_in.org[a][W-1]}}, r_in.org[a]};
            n_num0[a] = lo - o;
            n_num1[a] = hi - o;
            n_bnd[a]  = (r_in.dir[a] != '0);
            n_zout[a] = !n_bnd[a] && ((o < lo) || (o > hi));
        end
    end

    logic signed [W-1:0] quo0 [3];
    logic signed [W-1:0] quo1 [3];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        rbsi_div #(.W(W), .F(F)) u_div0 (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (n_num0[a]),
            .i_den (r_in.dir[a]),
            .o_quo (quo0[a])
        );
        rbsi_div #(.W(W), .F(F)) u_div1 (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (n_num1[a]),
            .i_den (r_in.dir[a]),
            .o_quo (quo1[a])
        );
    end

    // sideband line alongside the dividers
    t_side r_sb  [W];
    logic  r_sbv [W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < W; k++) r_sbv[k] <= 1'b0;
        end else if (en) begin
            r_sbv[0] <= r_in_vld;
            for (int k = 1; k < W; k++) r_sbv[k] <= r_sbv[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0].ray   <= r_in;
            r_sb[0].bnd   <= n_bnd;
            r_sb[0].zmiss <= |n_zout;
            for (int k = 1; k < W; k++) r_sb[k] <= r_sb[k-1];
        end
    end

    // ---------------- slab parameters ----------------
    t_side               r_n;
    logic                r_n_vld;
    logic signed [W-1:0] r_t0 [3];
    logic signed [W-1:0] r_t1 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_vld <= 1'b0;
        end else if (en) begin
            r_n_vld <= r_sbv[W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n <= r_sb[W-1];
            for (int a = 0; a < 3; a++) begin
                r_t0[a] <= quo0[a];
                r_t1[a] <= quo1[a];
            end
        end
    end

    // ---------------- entry / exit ----------------
    logic signed [W-1:0] n_near, n_far;
    logic                n_miss;

    always_comb begin
        logic signed [W-1:0] an, af;
        n_near = CMIN;
        n_far  = CMAX;
        for (int a = 0; a < 3; a++) begin
            an = (r_t0[a] < r_t1[a]) ? r_t0[a] : r_t1[a];
            af = (r_t0[a] < r_t1[a]) ? r_t1[a] : r_t0[a];
            if (r_n.bnd[a] && (an > n_near)) n_near = an;
            if (r_n.bnd[a] && (af < n_far))  n_far  = af;
        end
        n_miss = r_n.zmiss || (n_near > n_far)
              || (n_far < $signed(r_n.ray.lower)) || (n_near > $signed(r_n.ray.upper));
    end

    t_side               r_s;
    logic                r_s_vld;
    logic signed [W-1:0] r_s_t0 [3];
    logic signed [W-1:0] r_s_t1 [3];
    logic signed [W-1:0] r_near, r_far;
    logic                r_s_miss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (en) begin
            r_s_vld <= r_n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s      <= r_n;
            r_s_t0   <= r_t0;
            r_s_t1   <= r_t1;
            r_near   <= n_near;
            r_far    <= n_far;
            r_s_miss <= n_miss;
        end
    end

    // ---------------- t and normal ----------------
    logic signed [W-1:0] n_t;
    t_norm               n_norm [3];

    always_comb begin
        logic done;
        logic m0, m1;
        done  = 1'b0;
        n_t   = (r_near >= $signed(r_s.ray.lower)) ? r_near : r_far;
        for (int a = 0; a < 3; a++) begin
            m0 = r_s.bnd[a] && (n_t == r_s_t0[a]);
            m1 = r_s.bnd[a] && (n_t == r_s_t1[a]);
            n_norm[a] = NORM_ZERO;
            if (!done && (m0 || m1)) begin
                n_norm[a] = m0 ? NORM_NEG : NORM_POS;
                done      = 1'b1;
            end
        end
    end

    t_ray                r_tr;
    logic                r_t_vld;
    logic                r_t_hit;
    logic signed [W-1:0] r_t;
    t_norm               r_t_norm [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_vld <= 1'b0;
        end else if (en) begin
            r_t_vld <= r_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tr     <= r_s.ray;
            r_t_hit  <= !r_s_miss;
            r_t      <= n_t;
            r_t_norm <= n_norm;
        end
    end

    // ---------------- t * dir magnitude ----------------
    logic [2*W-1:0] n_prod [3];
    logic [2:0]     n_pneg;

    always_comb begin
        logic [W-1:0] tm, dm;
        tm = r_t[W-1] ? W'(-r_t) : r_t;
        for (int a = 0; a < 3; a++) begin
            dm = r_tr.dir[a][W-1] ? W'(-$signed(r_tr.dir[a])) : r_tr.dir[a];
            n_prod[a] = (2*W)'(tm) * (2*W)'(dm);
            n_pneg[a] = r_t[W-1] ^ r_tr.dir[a][W-1];
        end
    end

    logic [W-1:0]        r_m_org [3];
    logic                r_m_vld;
    logic                r_m_hit;
    logic signed [W-1:0] r_m_t;
    t_norm               r_m_norm [3];
    logic [2*W-1:0]      r_m_prod [3];
    logic [2:0]          r_m_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (en) begin
            r_m_vld <= r_t_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) r_m_org[a] <= r_tr.org[a];
            r_m_hit  <= r_t_hit;
            r_m_t    <= r_t;
            r_m_norm <= r_t_norm;
            r_m_prod <= n_prod;
            r_m_neg  <= n_pneg;
        end
    end

    // ---------------- hit point ----------------
    logic signed [W-1:0] n_pt [3];

    always_comb begin
        logic [2*W-1:0]      sh;
        logic signed [W+1:0] mag, sp, sum;
        for (int a = 0; a < 3; a++) begin
            sh  = r_m_prod[a] >> F;
            mag = (sh > (2*W)'(CMAX2)) ? (W+2)'(CMAX2 + 1) : (W+2)'(sh);
            sp  = r_m_neg[a] ? -mag : mag;
            if (sp > CMAX2) sp = CMAX2;
            sum = {{2{r_m_org[a][W-1]}}, r_m_org[a]} + sp;
            if (sum > CMAX2)      n_pt[a] = CMAX;
            else if (sum < CMIN2) n_pt[a] = CMIN;
            else                  n_pt[a] = sum[W-1:0];
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_hit      <= r_m_hit;
            o_t_hit    <= r_m_hit ? r_m_t   : '0;
            o_point_x  <= r_m_hit ? n_pt[0] : '0;
            o_point_y  <= r_m_hit ? n_pt[1] : '0;
            o_point_z  <= r_m_hit ? n_pt[2] : '0;
            o_normal_x <= r_m_hit ? r_m_norm[0] : NORM_ZERO;
            o_normal_y <= r_m_hit ? r_m_norm[1] : NORM_ZERO;
            o_normal_z <= r_m_hit ? r_m_norm[2] : NORM_ZERO;
        end
    end

endmodule

// ----- sv/rbsi_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_chk
// Port-level checks on the result channel of the slab intersection block.
// ----------------------------------------------------------------------------
module rbsi_chk #(
    parameter int W = 32
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input logic                o_hit,
    input logic signed [W-1:0] o_t_hit,
    input logic signed [W-1:0] o_point_x,
    input logic signed [W-1:0] o_point_y,
    input logic signed [W-1:0] o_point_z,
    input logic signed [1:0]   o_normal_x,
    input logic signed [1:0]   o_normal_y,
    input logic signed [1:0]   o_normal_z
);
    import rbsi_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_t_hit) && $stable(o_hit))
        else $error("result changed while held");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_t_hit == 0 && o_point_x == 0 && o_point_y == 0
            && o_point_z == 0 && o_normal_x == NORM_ZERO && o_normal_y == NORM_ZERO
            && o_normal_z == NORM_ZERO)
        else $error("miss result not cleared");

    a_one_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones({o_normal_x != NORM_ZERO, o_normal_y != NORM_ZERO,
            o_normal_z != NORM_ZERO}) <= 1)
        else $error("more than one face normal");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule

bind ray_box_slab_intersect_top rbsi_chk #(.W(COORD_WIDTH)) u_rbsi_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_hit      (o_hit),
    .o_t_hit    (o_t_hit),
    .o_point_x  (o_point_x),
    .o_point_y  (o_point_y),
    .o_point_z  (o_point_z),
    .o_normal_x (o_normal_x),
    .o_normal_y (o_normal_y),
    .o_normal_z (o_normal_z)
);
